// ===== src/pwcle_pkg.sv =====
// Shared types, constants and register codes for the pulse-width command line encoder.
package pwcle_pkg;

  // Data bits that the two velocity bytes and the LED byte carry
  localparam int unsigned RAW_BITS = 24;
  // Widest command the design supports; queue entries hold a command word of this many bits
  localparam int unsigned MAX_CMD_BITS = 32;
  localparam int unsigned MAX_IDX_W = $clog2(MAX_CMD_BITS);
  localparam int unsigned DEF_BITS_PER_COMMAND = 24;

  // Queue depths (log2)
  localparam int unsigned DEF_CMD_Q_AW = 2;
  localparam int unsigned DEF_OUT_Q_AW = 2;

  localparam int unsigned LEN_W = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SAMPLES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SAMPLES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_SAMPLES = 2'd2;

  // Register reset values
  localparam logic [11:0] RST_ZERO_SAMPLES  = 12'd45;
  localparam logic [11:0] RST_ONE_SAMPLES   = 12'd89;
  localparam logic [15:0] RST_RESET_SAMPLES = 16'd177;

  typedef struct packed {
    logic signed [7:0] left_velocity;
    logic signed [7:0] right_velocity;
    logic [7:0]        led_byte;
    logic [LEN_W-1:0]  room_left;
  } in_item_t;

  typedef struct packed {
    logic             pulse_level;
    logic [LEN_W-1:0] pulse_length;
    logic             is_fill;
    logic             last_pulse;
  } out_item_t;

  typedef struct packed {
    logic [11:0] zero_samples;
    logic [11:0] one_samples;
    logic [15:0] reset_samples;
  } cfg_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic [MAX_CMD_BITS-1:0] word;
    logic [LEN_W-1:0]        room;
    logic                    is_fill;
    logic                    flip;
  } cmd_t;

  // Back-end status seen by the top level checks
  typedef struct packed {
    logic emit;
    logic level;
    logic last;
    logic pop;
    logic polarity;
  } back_status_t;

endpackage

// ===== src/pwcle_fifo.sv =====
// Small synchronous FIFO used between the front, the back and the result port.
module pwcle_fifo #(
  parameter int unsigned W  = 8,
  parameter int unsigned AW = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int unsigned DEPTH = 2 ** AW;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== src/pwcle_front.sv =====
// Front end: accepts requests, builds the data word, sizes the command and classifies it.
module pwcle_front #(
  parameter int unsigned BITS_PER_COMMAND = pwcle_pkg::DEF_BITS_PER_COMMAND
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pwcle_pkg::cfg_t     cfg,
  input  logic                in_push,
  input  pwcle_pkg::in_item_t in_data,
  output logic                in_full,
  output logic                q_push,
  output pwcle_pkg::cmd_t     q_data,
  input  logic                q_full
);

  localparam int unsigned CW = $clog2(BITS_PER_COMMAND + 1);
  localparam int unsigned PW = CW + 12;
  localparam int unsigned TW = ((PW > 16) ? PW : 16) + 2;
  localparam int unsigned LW = pwcle_pkg::LEN_W;
  localparam int unsigned SW = (TW > LW) ? TW : LW;

  // Sign-magnitude velocity byte: positive sets the top bit
  function automatic logic [7:0] vel_byte(input logic [7:0] v);
    logic [7:0] neg;
    begin
      neg = 8'(~v + 8'd1);
      if (v == 8'd0 || v[7]) begin
        vel_byte = {1'b0, neg[6:0]};
      end else begin
        vel_byte = {1'b1, v[6:0]};
      end
    end
  endfunction

  logic [pwcle_pkg::MAX_CMD_BITS-1:0] raw_word;
  logic [BITS_PER_COMMAND-1:0]        word_in;

  // Stage A: data word, one count, room
  logic                        a_v_r, a_v_nxt;
  logic [BITS_PER_COMMAND-1:0] a_word_r;
  logic [CW-1:0]               a_ones_r;
  logic [LW-1:0]               a_room_r;

  // Stage B: per-kind length products, room checks
  logic                        b_v_r, b_v_nxt;
  logic [BITS_PER_COMMAND-1:0] b_word_r;
  logic [PW-1:0]               b_one_prod_r;
  logic [PW-1:0]               b_zero_prod_r;
  logic [LW-1:0]               b_room_r;
  logic                        b_no_room_r;
  logic                        b_flip_r;

  logic          a_ready, b_ready, a_load;
  logic [CW-1:0] a_zeros;
  logic [SW-1:0] total;
  logic          fits;

  // Build the command word, least significant bit sent first
  assign raw_word = pwcle_pkg::MAX_CMD_BITS'({in_data.led_byte,
                                              vel_byte(in_data.right_velocity),
                                              vel_byte(in_data.left_velocity)});
  assign word_in  = raw_word[BITS_PER_COMMAND-1:0];

  // Handshake between stages
  assign b_ready = !b_v_r || b_no_room_r || !q_full;
  assign a_ready = !a_v_r || b_ready;
  assign in_full = !a_ready;
  assign a_load  = in_push && a_ready;

  always_comb begin
    a_v_nxt = a_ready ? in_push : a_v_r;
    b_v_nxt = b_ready ? a_v_r : b_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
    end
  end

  // Stage A payload
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_word_r <= word_in;
      a_ones_r <= CW'($countones(word_in));
      a_room_r <= in_data.room_left;
    end
  end

  assign a_zeros = CW'(BITS_PER_COMMAND) - a_ones_r;

  // Stage B payload
  always_ff @(posedge clk) begin
    if (a_v_r && b_ready) begin
      b_word_r      <= a_word_r;
      b_one_prod_r  <= PW'(a_ones_r) * PW'(cfg.one_samples);
      b_zero_prod_r <= PW'(a_zeros) * PW'(cfg.zero_samples);
      b_room_r      <= a_room_r;
      b_no_room_r   <= (a_room_r == '0);
      b_flip_r      <= (a_room_r < LW'(cfg.zero_samples >> 1));
    end
  end

  // Total command length against the room left
  assign total = SW'(b_one_prod_r) + SW'(b_zero_prod_r) + SW'(cfg.reset_samples);
  assign fits  = total < SW'(b_room_r);

  // Push classified commands; drop those with no room
  assign q_push         = b_v_r && !b_no_room_r && !q_full;
  assign q_data.word    = pwcle_pkg::MAX_CMD_BITS'(b_word_r);
  assign q_data.room    = b_room_r;
  assign q_data.is_fill = !fits;
  assign q_data.flip    = b_flip_r;

endmodule

// ===== src/pwcle_back.sv =====
// Back end: walks a classified command and emits one pulse per cycle while the result queue has space.
module pwcle_back #(
  parameter int unsigned BITS_PER_COMMAND = pwcle_pkg::DEF_BITS_PER_COMMAND
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pwcle_pkg::cfg_t         cfg,
  input  pwcle_pkg::cmd_t         q_data,
  input  logic                    q_empty,
  output logic                    q_pop,
  output logic                    o_push,
  output pwcle_pkg::out_item_t    o_data,
  input  logic                    o_full,
  output pwcle_pkg::back_status_t status
);

  localparam int unsigned CW = $clog2(BITS_PER_COMMAND + 1);
  localparam int unsigned LW = pwcle_pkg::LEN_W;

  logic          pol_r, pol_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic                           emit, level, last, data_bit;
  logic [pwcle_pkg::MAX_IDX_W-1:0] bit_idx;
  logic [CW-1:0]                  cnt_dec;

  assign emit     = !q_empty && !o_full;
  assign last     = q_data.is_fill || (cnt_r == CW'(BITS_PER_COMMAND));
  assign level    = q_data.is_fill ? (pol_r ^ q_data.flip) : pol_r;
  assign cnt_dec  = cnt_r - 1'b1;
  assign bit_idx  = pwcle_pkg::MAX_IDX_W'(cnt_dec);
  assign data_bit = q_data.word[bit_idx];

  // Select the pulse length for the current step
  always_comb begin
    o_data.pulse_level = level;
    o_data.is_fill     = q_data.is_fill;
    o_data.last_pulse  = last;
    if (q_data.is_fill) begin
      o_data.pulse_length = q_data.room;
    end else if (cnt_r == '0) begin
      o_data.pulse_length = LW'(cfg.reset_samples);
    end else if (data_bit) begin
      o_data.pulse_length = LW'(cfg.one_samples);
    end else begin
      o_data.pulse_length = LW'(cfg.zero_samples);
    end
  end

  assign o_push = emit;
  assign q_pop  = emit && last;

  // Advance step count and polarity
  always_comb begin
    cnt_nxt = cnt_r;
    pol_nxt = pol_r;
    if (emit) begin
      pol_nxt = !level;
      if (last) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r <= 1'b1;
      cnt_r <= '0;
    end else begin
      pol_r <= pol_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign status.emit     = emit;
  assign status.level    = level;
  assign status.last     = last;
  assign status.pop      = q_pop;
  assign status.polarity = pol_r;

endmodule

// ===== src/pulse_width_command_line_encoder_core.sv =====
// Top level of the pulse-width command line encoder: front, command queue, back, result queue.
//
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+------------------------------
//  request  | in_push, in_full, in_data           | taken when push && !full
//  result   | out_pop, out_empty, out_data        | taken when pop && !empty
//  config   | cfg_valid, cfg_ready, cfg_index/data| taken when valid && ready
//
// A command that fits yields 1 + BITS_PER_COMMAND pulses, one per cycle from the back end
// while the result queue has space; a fill yields a single pulse. The front registers
// requests in stages A and B; a new request is taken each cycle until the command queue
// fills. Reset is synchronous: polarity positive, registers at their reset values.
// Either side may stall; the queues hold requests and pulses until the other side moves.
module pulse_width_command_line_encoder_core #(
  parameter int unsigned BITS_PER_COMMAND = pwcle_pkg::DEF_BITS_PER_COMMAND,
  parameter int unsigned CMD_Q_AW         = pwcle_pkg::DEF_CMD_Q_AW,
  parameter int unsigned OUT_Q_AW         = pwcle_pkg::DEF_OUT_Q_AW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  pwcle_pkg::in_item_t                 in_data,
  output logic                                in_full,
  input  logic                                out_pop,
  output pwcle_pkg::out_item_t                out_data,
  output logic                                out_empty,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pwcle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pwcle_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pwcle_pkg::cfg_t cfg_r, cfg_nxt;

  logic                    cq_push, cq_full, cq_pop, cq_empty;
  pwcle_pkg::cmd_t         cq_wdata, cq_rdata;
  logic                    oq_push, oq_full;
  pwcle_pkg::out_item_t    oq_wdata;
  pwcle_pkg::back_status_t bk_status;

  // Hold configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        pwcle_pkg::CFG_ZERO_SAMPLES:  cfg_nxt.zero_samples  = cfg_data[11:0];
        pwcle_pkg::CFG_ONE_SAMPLES:   cfg_nxt.one_samples   = cfg_data[11:0];
        pwcle_pkg::CFG_RESET_SAMPLES: cfg_nxt.reset_samples = cfg_data;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_samples  <= pwcle_pkg::RST_ZERO_SAMPLES;
      cfg_r.one_samples   <= pwcle_pkg::RST_ONE_SAMPLES;
      cfg_r.reset_samples <= pwcle_pkg::RST_RESET_SAMPLES;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Accept and classify requests
  pwcle_front #(
    .BITS_PER_COMMAND(BITS_PER_COMMAND)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_push  (cq_push),
    .q_data  (cq_wdata),
    .q_full  (cq_full)
  );

  // Queue classified commands
  pwcle_fifo #(
    .W  ($bits(pwcle_pkg::cmd_t)),
    .AW (CMD_Q_AW)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (cq_wdata),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  // Emit pulses
  pwcle_back #(
    .BITS_PER_COMMAND(BITS_PER_COMMAND)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_data  (cq_rdata),
    .q_empty (cq_empty),
    .q_pop   (cq_pop),
    .o_push  (oq_push),
    .o_data  (oq_wdata),
    .o_full  (oq_full),
    .status  (bk_status)
  );

  // Queue pulses toward the result port
  pwcle_fifo #(
    .W  ($bits(pwcle_pkg::out_item_t)),
    .AW (OUT_Q_AW)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

  // Back end never pushes into a full result queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.emit |-> !oq_full)
    else $error("pulse emitted into full result queue");

  // A command leaves the queue only with its last pulse
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.pop |-> (bk_status.emit && bk_status.last))
    else $error("command popped before its last pulse");

  // Polarity after a pulse is the opposite of that pulse's level
  a_pol_flips: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.emit |=> (bk_status.polarity == !$past(bk_status.level)))
    else $error("polarity did not flip after pulse");

  // Idle back end keeps its polarity
  a_pol_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !bk_status.emit |=> $stable(bk_status.polarity))
    else $error("polarity changed without a pulse");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the pulse-width command line encoder core.
module testbench;

  localparam int unsigned CMD_BITS = pwcle_pkg::DEF_BITS_PER_COMMAND;
  localparam int unsigned LEN_W = pwcle_pkg::LEN_W;
  localparam int unsigned RAW_BITS = pwcle_pkg::RAW_BITS;
  localparam int unsigned CFG_IDX_W = pwcle_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = pwcle_pkg::CFG_DATA_W;
  // Register index past the list; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // Front latency plus one full command in the back end, with margin
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam logic [LEN_W-1:0] ROOM_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  pwcle_pkg::in_item_t in_data = '0;
  logic in_full;
  logic out_pop = 1'b0;
  pwcle_pkg::out_item_t out_data;
  logic out_empty;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the line polarity
  logic [11:0] zero_len;
  logic [11:0] one_len;
  logic [15:0] rst_len;
  logic line_level;
  pwcle_pkg::out_item_t pulse_q[$];

  int unsigned send_gap_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned cmds_sent = 0;
  int unsigned pulses_seen = 0;
  int unsigned fills_seen = 0;
  int unsigned full_stalls = 0;
  int unsigned settings_used = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  pulse_width_command_line_encoder_core #(
    .BITS_PER_COMMAND(CMD_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_data(in_data),
    .in_full(in_full),
    .out_pop(out_pop),
    .out_data(out_data),
    .out_empty(out_empty),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sign-magnitude byte: top bit set only for a positive velocity
  function automatic logic [7:0] encode_velocity(logic [7:0] v);
    logic [7:0] neg;
    neg = 8'd0 - v;
    if (v == 8'd0 || v[7]) return {1'b0, neg[6:0]};
    return {1'b1, v[6:0]};
  endfunction

  function automatic logic [RAW_BITS-1:0] command_word(pwcle_pkg::in_item_t c);
    return {c.led_byte, encode_velocity(c.right_velocity), encode_velocity(c.left_velocity)};
  endfunction

  // Bits past the three bytes go out as zeros
  function automatic logic [LEN_W-1:0] bit_len(logic [RAW_BITS-1:0] w, int i);
    if (i < RAW_BITS && w[i]) return LEN_W'(one_len);
    return LEN_W'(zero_len);
  endfunction

  function automatic int unsigned command_total(pwcle_pkg::in_item_t c);
    logic [RAW_BITS-1:0] w;
    int unsigned sum;
    w = command_word(c);
    sum = 32'(rst_len);
    for (int i = 0; i < CMD_BITS; i++) sum += 32'(bit_len(w, i));
    return sum;
  endfunction

  // Queue the pulses one accepted request puts on the line and advance polarity
  function automatic void predict_pulses(pwcle_pkg::in_item_t c);
    logic [RAW_BITS-1:0] w;
    pwcle_pkg::out_item_t p;
    logic lvl;
    w = command_word(c);
    lvl = line_level;
    if (c.room_left == '0) return;
    if (command_total(c) < c.room_left) begin
      p = '{lvl, LEN_W'(rst_len), 1'b0, 1'b0};
      pulse_q.push_back(p);
      for (int i = 0; i < CMD_BITS; i++) begin
        lvl = ~lvl;
        p = '{lvl, bit_len(w, i), 1'b0, i == CMD_BITS - 1};
        pulse_q.push_back(p);
      end
    end else begin
      if (c.room_left < zero_len / 2) lvl = ~lvl;
      p = '{lvl, c.room_left, 1'b1, 1'b1};
      pulse_q.push_back(p);
    end
    line_level = ~lvl;
  endfunction

  function automatic logic [7:0] pick_velocity();
    if ($urandom_range(5) != 0) return 8'($urandom());
    case ($urandom_range(4))
      0: return 8'h80;
      1: return 8'hFF;
      2: return 8'h00;
      3: return 8'h01;
      default: return 8'h7F;
    endcase
  endfunction

  // Mostly commands that fit, then fills, rooms near the flip threshold and raw noise
  function automatic pwcle_pkg::in_item_t rand_cmd();
    pwcle_pkg::in_item_t c;
    int unsigned total;
    int unsigned roll;
    c.left_velocity = pick_velocity();
    c.right_velocity = pick_velocity();
    c.led_byte = 8'($urandom());
    c.room_left = '0;
    total = command_total(c);
    roll = $urandom_range(99);
    if (roll < 60)
      c.room_left = LEN_W'(total + 1 + $urandom_range($urandom_range(1) ? 3 : 20000));
    else if (roll < 85)
      c.room_left = LEN_W'($urandom_range(total, 1));
    else if (roll < 93)
      c.room_left = LEN_W'($urandom_range(32'(zero_len)));
    else
      c.room_left = LEN_W'($urandom());
    return c;
  endfunction

  // Check each popped pulse, count input stalls, then choose the next pop
  always @(posedge clk) begin
    pwcle_pkg::out_item_t want;
    if (rst_n && in_push && in_full) full_stalls++;
    if (rst_n && out_pop && !out_empty) begin
      if (pulse_q.size() == 0) begin
        $error("unexpected pulse: level %0d length %0d fill %0d last %0d",
               out_data.pulse_level, out_data.pulse_length, out_data.is_fill,
               out_data.last_pulse);
        errors++;
      end else begin
        want = pulse_q.pop_front();
        pulses_seen++;
        if (want.is_fill) fills_seen++;
        if (out_data.pulse_level !== want.pulse_level) begin
          $error("pulse_level: expected %0d, got %0d", want.pulse_level, out_data.pulse_level);
          errors++;
        end
        if (out_data.pulse_length !== want.pulse_length) begin
          $error("pulse_length: expected %0d, got %0d", want.pulse_length,
                 out_data.pulse_length);
          errors++;
        end
        if (out_data.is_fill !== want.is_fill) begin
          $error("is_fill: expected %0d, got %0d", want.is_fill, out_data.is_fill);
          errors++;
        end
        if (out_data.last_pulse !== want.last_pulse) begin
          $error("last_pulse: expected %0d, got %0d", want.last_pulse, out_data.last_pulse);
          errors++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_cmd(pwcle_pkg::in_item_t c);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    if (send_gap_pct != 0 && $urandom_range(19) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(40, 1)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_full);
    predict_pulses(c);
    cmds_sent++;
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send_cmd(rand_cmd());
  endtask

  // Drop push, wait for every predicted pulse, then let the pipeline settle
  task automatic wait_idle();
    in_push <= 1'b0;
    while (pulse_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pwcle_pkg::CFG_ZERO_SAMPLES: zero_len = val[11:0];
      pwcle_pkg::CFG_ONE_SAMPLES: one_len = val[11:0];
      pwcle_pkg::CFG_RESET_SAMPLES: rst_len = val;
      default: ;
    endcase
  endtask

  task automatic set_lengths(logic [15:0] z, logic [15:0] o, logic [15:0] r,
                             bit poke_spare = 1'b0);
    wait_idle();
    write_reg(pwcle_pkg::CFG_ZERO_SAMPLES, z);
    write_reg(pwcle_pkg::CFG_ONE_SAMPLES, o);
    write_reg(pwcle_pkg::CFG_RESET_SAMPLES, r);
    if (poke_spare) write_reg(CFG_SPARE, 16'hFFFF);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Field extremes, fit/fill boundaries, flip threshold and empty room at reset lengths
  task automatic test_directed();
    pwcle_pkg::in_item_t c;
    int unsigned total;
    send_gap_pct = 0;
    pop_stall_pct = 0;
    c = '{8'h80, 8'h7F, 8'h00, ROOM_MAX}; send_cmd(c);
    c = '{8'h7F, 8'h80, 8'hFF, ROOM_MAX}; send_cmd(c);
    c = '{8'hFF, 8'h00, 8'hAA, ROOM_MAX}; send_cmd(c);
    c = '{8'h01, 8'hFF, 8'h55, ROOM_MAX}; send_cmd(c);
    c = '{8'h00, 8'h01, 8'h0F, ROOM_MAX}; send_cmd(c);
    c = '{8'h12, 8'hF3, 8'h96, 20'd0};
    total = command_total(c);
    c.room_left = LEN_W'(total); send_cmd(c);
    c.room_left = LEN_W'(total + 1); send_cmd(c);
    c.room_left = 20'd1; send_cmd(c);
    c.room_left = LEN_W'(zero_len / 2 - 1); send_cmd(c);
    c.room_left = LEN_W'(zero_len / 2); send_cmd(c);
    c.room_left = 20'd0; send_cmd(c);
    c.room_left = 20'd0; send_cmd(c);
    c.room_left = LEN_W'(total + 1); send_cmd(c);
    c = '{8'h00, 8'h00, 8'h00, ROOM_MAX}; send_cmd(c);
  endtask

  // Sweep the length registers through their extremes, zero, truncation and a spare index
  task automatic test_lengths();
    send_gap_pct = 20;
    pop_stall_pct = 20;
    set_lengths(16'd1, 16'd1, 16'd1);
    send_random(10);
    set_lengths(16'd4095, 16'd4095, 16'hFFFF);
    send_random(10);
    set_lengths(16'd0, 16'd0, 16'd0);
    send_random(6);
    set_lengths(16'hF02D, 16'hA059, 16'd300, 1'b1);
    send_random(10);
    set_lengths(16'($urandom_range(4095, 1)), 16'($urandom_range(4095, 1)),
                16'($urandom_range(65535, 1)));
    send_random(10);
    set_lengths(16'(pwcle_pkg::RST_ZERO_SAMPLES), 16'(pwcle_pkg::RST_ONE_SAMPLES),
                pwcle_pkg::RST_RESET_SAMPLES);
    send_random(10);
  endtask

  // Hold off the receiver so both queues fill and push stalls, then pause the sender
  task automatic test_backpressure();
    wait_idle();
    send_gap_pct = 0;
    pop_stall_pct = 0;
    hold_cycles = 400;
    send_random(14);
    wait_idle();
    send_random(6);
  endtask

  // Long random runs under each idling pattern, new lengths for each phase after the first
  task automatic test_idle_phases();
    int unsigned gap_pct [4] = '{0, 65, 0, 36};
    int unsigned stall_pct [4] = '{0, 0, 65, 36};
    for (int ph = 0; ph < 4; ph++) begin
      if (ph != 0)
        set_lengths(16'($urandom_range(200, 1)), 16'($urandom_range(400, 1)),
                    16'($urandom_range(1000, 1)));
      else
        wait_idle();
      send_gap_pct = gap_pct[ph];
      pop_stall_pct = stall_pct[ph];
      send_random(95);
    end
  endtask

  initial begin
    int unsigned waited;
    zero_len = pwcle_pkg::RST_ZERO_SAMPLES;
    one_len = pwcle_pkg::RST_ONE_SAMPLES;
    rst_len = pwcle_pkg::RST_RESET_SAMPLES;
    line_level = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_lengths();
    test_backpressure();
    test_idle_phases();
    in_push <= 1'b0;
    waited = 0;
    while (pulse_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pulse_q.size() != 0) begin
      $error("%0d predicted pulses never arrived", pulse_q.size());
      errors++;
    end
    $display("Covered %0d commands over %0d length settings: %0d pulses checked, %0d fills.",
             cmds_sent, settings_used, pulses_seen, fills_seen);
    $display("Input stalled on a full queue for %0d cycles; %0d mismatches.",
             full_stalls, errors);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pwcle_pkg.sv
src/pwcle_fifo.sv
src/pwcle_front.sv
src/pwcle_back.sv
src/pulse_width_command_line_encoder_core.sv
tb/sv/testbench.sv
